// ===== rtl/pbv_pkg.sv =====
// pbv_pkg: shared types and constants for the pulse batch validator.
// Used by pbv_cfg, pbv_core, pulse_batch_validator and pbv_checker.
`default_nettype none

package pbv_pkg;

    localparam int PIN_COUNT = 64;
    localparam int PIN_W     = 6;
    localparam int PIN_IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam logic [PIN_W:0] PIN_LIMIT = (PIN_W + 1)'(PIN_COUNT);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [6:0]  MAX_LINES_RST    = 7'd8;
    localparam logic [7:0]  MAX_EDGES_RST    = 8'd64;
    localparam logic [15:0] MIN_EDGE_MS_RST  = 16'd1;
    localparam logic [31:0] MAX_BATCH_MS_RST = 32'd30000;

    typedef enum logic [1:0] {
        REG_MAX_LINES    = 2'd0,
        REG_MAX_EDGES    = 2'd1,
        REG_MIN_EDGE_MS  = 2'd2,
        REG_MAX_BATCH_MS = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_NO_LINES    = 3'd1,
        ERR_MANY_LINES  = 3'd2,
        ERR_NO_EDGES    = 3'd3,
        ERR_MANY_EDGES  = 3'd4,
        ERR_SHORT_EDGE  = 3'd5,
        ERR_DUP_PIN     = 3'd6,
        ERR_TOO_LONG    = 3'd7
    } err_code_t;

    typedef struct packed {
        logic [6:0]  max_lines;
        logic [7:0]  max_edges;
        logic [15:0] min_edge_ms;
        logic [31:0] max_batch_ms;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/pbv_cfg.sv =====
// pbv_cfg: APB-style register file holding the validator limits.
// Depends on pbv_pkg.
`default_nettype none

module pbv_cfg
    import pbv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MAX_LINES:    cfg_next.max_lines    = pwdata[6:0];
                REG_MAX_EDGES:    cfg_next.max_edges    = pwdata[7:0];
                REG_MIN_EDGE_MS:  cfg_next.min_edge_ms  = pwdata[15:0];
                REG_MAX_BATCH_MS: cfg_next.max_batch_ms = pwdata[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_LINES:    prdata = {25'd0, cfg_reg.max_lines};
            REG_MAX_EDGES:    prdata = {24'd0, cfg_reg.max_edges};
            REG_MIN_EDGE_MS:  prdata = {16'd0, cfg_reg.min_edge_ms};
            REG_MAX_BATCH_MS: prdata = cfg_reg.max_batch_ms;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_lines    <= MAX_LINES_RST;
            cfg_reg.max_edges    <= MAX_EDGES_RST;
            cfg_reg.min_edge_ms  <= MIN_EDGE_MS_RST;
            cfg_reg.max_batch_ms <= MAX_BATCH_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pbv_core.sv =====
// pbv_core: input register, per-edge check and batch state update, result register.
// Depends on pbv_pkg.
`default_nettype none

module pbv_core
    import pbv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire logic [7:0]       batch_lines,
    input  wire logic [PIN_W-1:0] pin,
    input  wire logic [31:0]      start_ms,
    input  wire logic [7:0]       line_edges,
    input  wire logic [31:0]      edge_ms,
    input  wire logic             line_end,
    input  wire logic             batch_end,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic [2:0]            error_code,
    output logic [31:0]           duration_ms
);

    function automatic err_code_t raise_err(input err_code_t cur, input err_code_t code);
        return (cur == ERR_OK) ? code : cur;
    endfunction

    // input register
    logic             in_vld_reg;
    logic             in_vld_next;
    logic [7:0]       blines_reg;
    logic [PIN_W-1:0] pin_reg;
    logic [31:0]      start_reg;
    logic [7:0]       ledges_reg;
    logic [31:0]      edge_reg;
    logic             lend_reg;
    logic             bend_reg;

    // batch state
    logic [PIN_COUNT-1:0] pins_used_reg, pins_used_next;
    err_code_t            first_error_reg, first_error_next;
    logic [31:0]          line_sum_reg, line_sum_next;
    logic [31:0]          longest_ms_reg, longest_ms_next;
    logic                 dup_pending_reg, dup_pending_next;
    logic                 mid_line_reg, mid_line_next;
    logic                 mid_batch_reg, mid_batch_next;

    // result register
    logic       out_vld_reg, out_vld_next;
    err_code_t  err_out_reg, err_out_next;
    logic [31:0] total_reg, total_next;

    logic        accept;
    logic        process;
    logic        pin_tracked;
    logic [32:0] sum_ext;

    assign process    = in_vld_reg && (!bend_reg || !out_vld_reg || !result_stall);
    assign item_stall = in_vld_reg && !process;
    assign accept     = item_valid && !item_stall;
    assign pin_tracked = ({1'b0, pin_reg} < PIN_LIMIT);

    assign result_valid = out_vld_reg;
    assign error_code   = err_out_reg;
    assign duration_ms  = total_reg;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (process)
            in_vld_next = 1'b0;
    end

    always_comb
    begin
        pins_used_next   = pins_used_reg;
        first_error_next = first_error_reg;
        line_sum_next    = line_sum_reg;
        longest_ms_next  = longest_ms_reg;
        dup_pending_next = dup_pending_reg;
        mid_line_next    = mid_line_reg;
        mid_batch_next   = mid_batch_reg;
        sum_ext          = '0;

        if (!mid_batch_reg)
        begin
            if (blines_reg == 8'd0)
                first_error_next = raise_err(first_error_next, ERR_NO_LINES);
            else if (blines_reg > {1'b0, cfg.max_lines})
                first_error_next = raise_err(first_error_next, ERR_MANY_LINES);
            mid_batch_next = 1'b1;
        end

        if (!mid_line_reg)
        begin
            if (ledges_reg == 8'd0)
                first_error_next = raise_err(first_error_next, ERR_NO_EDGES);
            else if (ledges_reg > cfg.max_edges)
                first_error_next = raise_err(first_error_next, ERR_MANY_EDGES);
            dup_pending_next = 1'b0;
            if (pin_tracked)
            begin
                dup_pending_next = pins_used_reg[pin_reg[PIN_IDX_W-1:0]];
                pins_used_next[pin_reg[PIN_IDX_W-1:0]] = 1'b1;
            end
            line_sum_next = start_reg;
            mid_line_next = 1'b1;
        end

        // edge length uses this item's edge count
        if (ledges_reg != 8'd0)
        begin
            if (edge_reg < {16'd0, cfg.min_edge_ms})
                first_error_next = raise_err(first_error_next, ERR_SHORT_EDGE);
            sum_ext       = {1'b0, line_sum_next} + {1'b0, edge_reg};
            line_sum_next = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
        end

        if (lend_reg || bend_reg)
        begin
            if (dup_pending_next)
                first_error_next = raise_err(first_error_next, ERR_DUP_PIN);
            if (line_sum_next > longest_ms_reg)
                longest_ms_next = line_sum_next;
            dup_pending_next = 1'b0;
            mid_line_next    = 1'b0;
        end

        if (bend_reg && (longest_ms_next > cfg.max_batch_ms))
            first_error_next = raise_err(first_error_next, ERR_TOO_LONG);

        err_out_next = first_error_next;
        total_next   = (first_error_next == ERR_OK) ? longest_ms_next : 32'd0;

        if (bend_reg)
        begin
            pins_used_next   = '0;
            first_error_next = ERR_OK;
            line_sum_next    = '0;
            longest_ms_next  = '0;
            dup_pending_next = 1'b0;
            mid_line_next    = 1'b0;
            mid_batch_next   = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (process && bend_reg)
            out_vld_next = 1'b1;
        else if (!result_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            pins_used_reg   <= '0;
            first_error_reg <= ERR_OK;
            line_sum_reg    <= '0;
            longest_ms_reg  <= '0;
            dup_pending_reg <= 1'b0;
            mid_line_reg    <= 1'b0;
            mid_batch_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (process)
            begin
                pins_used_reg   <= pins_used_next;
                first_error_reg <= first_error_next;
                line_sum_reg    <= line_sum_next;
                longest_ms_reg  <= longest_ms_next;
                dup_pending_reg <= dup_pending_next;
                mid_line_reg    <= mid_line_next;
                mid_batch_reg   <= mid_batch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blines_reg <= batch_lines;
            pin_reg    <= pin;
            start_reg  <= start_ms;
            ledges_reg <= line_edges;
            edge_reg   <= edge_ms;
            lend_reg   <= line_end;
            bend_reg   <= batch_end;
        end
        if (process && bend_reg)
        begin
            err_out_reg <= err_out_next;
            total_reg   <= total_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pulse_batch_validator.sv =====
// Pulse batch validator: one edge item per cycle, result on each batch end item.
// Result: an accepted batch end item passes the input register, then loads the result register.
// Throughput: one item per cycle; input stalls only when a batch end item
// meets a full result register that is itself stalled.
// Reset: limits return to 8 / 64 / 1 / 30000, batch state cleared, no result pending.
// Depends on pbv_pkg, pbv_cfg, pbv_core.
`default_nettype none

module pulse_batch_validator
    import pbv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire logic [7:0]        batch_lines,
    input  wire logic [PIN_W-1:0]  pin,
    input  wire logic [31:0]       start_ms,
    input  wire logic [7:0]        line_edges,
    input  wire logic [31:0]       edge_ms,
    input  wire logic              line_end,
    input  wire logic              batch_end,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic [2:0]             error_code,
    output logic [31:0]            duration_ms
);

    cfg_t cfg;

    pbv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbv_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .batch_lines  (batch_lines),
        .pin          (pin),
        .start_ms     (start_ms),
        .line_edges   (line_edges),
        .edge_ms      (edge_ms),
        .line_end     (line_end),
        .batch_end    (batch_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .error_code   (error_code),
        .duration_ms  (duration_ms)
    );

endmodule

`default_nettype wire

// ===== rtl/pbv_checker.sv =====
// pbv_checker: port-level assertions for pulse_batch_validator, bound to the top.
// Depends on pbv_pkg.
`default_nettype none

module pbv_checker
    import pbv_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [2:0]  error_code,
    input wire logic [31:0] duration_ms
);

    // stalled result transfer holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(error_code)
            && $stable(duration_ms))
        else $error("result changed while stalled");

    // total only reported on a clean batch
    a_total_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (error_code != ERR_OK) |-> duration_ms == 32'd0)
        else $error("nonzero total with error code");

    // input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without result backpressure");

endmodule

bind pulse_batch_validator pbv_checker u_pbv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .error_code   (error_code),
    .duration_ms  (duration_ms)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for pulse_batch_validator: directed batches, then random phases
// under several limit settings, with every batch verdict predicted and compared.
// Depends on pbv_pkg and the pulse_batch_validator RTL.
`timescale 1ns / 100ps

module testbench
    import pbv_pkg::*;
();

    typedef struct {
        logic [7:0]       batch_lines;
        logic [PIN_W-1:0] pin;
        logic [31:0]      start_ms;
        logic [7:0]       line_edges;
        logic [31:0]      edge_ms;
        logic             line_end;
        logic             batch_end;
    } batch_item_t;

    typedef struct {
        err_code_t   code;
        logic [31:0] total;
    } batch_verdict_t;

    class verdict_board;
        logic [6:0]           lim_lines;
        logic [7:0]           lim_edges;
        logic [15:0]          lim_edge_ms;
        logic [31:0]          lim_batch_ms;
        logic [PIN_COUNT-1:0] pins_used;
        err_code_t            first_err;
        logic [31:0]          line_sum;
        logic [31:0]          longest;
        bit                   dup_pending;
        bit                   in_line;
        bit                   in_batch;
        batch_verdict_t       pending_verdicts[$];
        int                   failures;

        function new();
            lim_lines    = MAX_LINES_RST;
            lim_edges    = MAX_EDGES_RST;
            lim_edge_ms  = MIN_EDGE_MS_RST;
            lim_batch_ms = MAX_BATCH_MS_RST;
            failures     = 0;
            clear_batch();
        endfunction

        function void clear_batch();
            pins_used   = '0;
            first_err   = ERR_OK;
            line_sum    = '0;
            longest     = '0;
            dup_pending = 1'b0;
            in_line     = 1'b0;
            in_batch    = 1'b0;
        endfunction

        function void set_limit(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_MAX_LINES:    lim_lines    = value[6:0];
                REG_MAX_EDGES:    lim_edges    = value[7:0];
                REG_MIN_EDGE_MS:  lim_edge_ms  = value[15:0];
                REG_MAX_BATCH_MS: lim_batch_ms = value;
                default: ;
            endcase
        endfunction

        function void latch_error(err_code_t code);
            if (first_err == ERR_OK)
                first_err = code;
        endfunction

        function void flag(string msg);
            if (failures < 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
            failures++;
        endfunction

        function void take_item(batch_item_t it);
            batch_verdict_t v;
            logic [32:0]    acc;
            if (!in_batch)
            begin
                if (it.batch_lines == 0)
                    latch_error(ERR_NO_LINES);
                else if (it.batch_lines > lim_lines)
                    latch_error(ERR_MANY_LINES);
                in_batch = 1'b1;
            end
            if (!in_line)
            begin
                if (it.line_edges == 0)
                    latch_error(ERR_NO_EDGES);
                else if (it.line_edges > lim_edges)
                    latch_error(ERR_MANY_EDGES);
                dup_pending = 1'b0;
                if (int'(it.pin) < PIN_COUNT)
                begin
                    dup_pending        = pins_used[it.pin];
                    pins_used[it.pin]  = 1'b1;
                end
                line_sum = it.start_ms;
                in_line  = 1'b1;
            end
            if (it.line_edges != 0)
            begin
                if (it.edge_ms < lim_edge_ms)
                    latch_error(ERR_SHORT_EDGE);
                acc      = {1'b0, line_sum} + {1'b0, it.edge_ms};
                line_sum = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
            end
            if (it.line_end || it.batch_end)
            begin
                if (dup_pending)
                    latch_error(ERR_DUP_PIN);
                if (line_sum > longest)
                    longest = line_sum;
                dup_pending = 1'b0;
                in_line     = 1'b0;
            end
            if (!it.batch_end)
                return;
            if (longest > lim_batch_ms)
                latch_error(ERR_TOO_LONG);
            v.code  = first_err;
            v.total = (first_err == ERR_OK) ? longest : 32'd0;
            pending_verdicts.push_back(v);
            clear_batch();
        endfunction

        function void check_verdict(logic [2:0] code, logic [31:0] total);
            batch_verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                flag($sformatf("unexpected result error_code=%0d duration_ms=%0d", code, total));
                return;
            end
            v = pending_verdicts.pop_front();
            if (code !== v.code)
                flag($sformatf("error_code expected %s (%0d) got %0d",
                               v.code.name(), v.code, code));
            if (total !== v.total)
                flag($sformatf("duration_ms expected %0d got %0d", v.total, total));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid;
    logic              item_stall;
    logic [7:0]        batch_lines;
    logic [PIN_W-1:0]  pin;
    logic [31:0]       start_ms;
    logic [7:0]        line_edges;
    logic [31:0]       edge_ms;
    logic              line_end;
    logic              batch_end;
    logic              result_valid;
    logic              result_stall;
    logic [2:0]        error_code;
    logic [31:0]       duration_ms;

    verdict_board board = new();
    bit           calm  = 1'b0;

    pulse_batch_validator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .batch_lines  (batch_lines),
        .pin          (pin),
        .start_ms     (start_ms),
        .line_edges   (line_edges),
        .edge_ms      (edge_ms),
        .line_end     (line_end),
        .batch_end    (batch_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .error_code   (error_code),
        .duration_ms  (duration_ms)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stall bursts until the quiet tail
    initial
    begin
        int unsigned burst;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 6) == 0)
            begin
                burst        = $urandom_range(1, 8);
                result_stall = 1'b1;
                repeat (burst) @(negedge clk);
                result_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            board.check_verdict(error_code, duration_ms);

    function automatic batch_item_t make_item(logic [7:0] bl, logic [PIN_W-1:0] p,
                                              logic [31:0] st, logic [7:0] le,
                                              logic [31:0] em, logic lend, logic bend);
        batch_item_t it;
        it.batch_lines = bl;
        it.pin         = p;
        it.start_ms    = st;
        it.line_edges  = le;
        it.edge_ms     = em;
        it.line_end    = lend;
        it.batch_end   = bend;
        return it;
    endfunction

    task automatic send_item(input batch_item_t it);
        int unsigned gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap        = $urandom_range(1, 8);
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        batch_lines = it.batch_lines;
        pin         = it.pin;
        start_ms    = it.start_ms;
        line_edges  = it.line_edges;
        edge_ms     = it.edge_ms;
        line_end    = it.line_end;
        batch_end   = it.batch_end;
        item_valid  = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        board.take_item(it);
    endtask

    task automatic write_limit(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(int'(idx) * 4);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_limit(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drop valid, drain outstanding verdicts, then cover the result latency
    task automatic settle();
        @(negedge clk);
        item_valid = 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_batch(output int sent);
        batch_item_t    it;
        int unsigned    n_lines, lim, cap, ln, k, e, p, elim, r;
        logic [7:0]     decl_lines, decl_edges;
        logic [31:0]    st;
        logic [63:0]    taken;
        longint         avail, top;
        bit             big, drop_lend, last;
        sent = 0;
        if ($urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(1, 8);
            for (e = 0; e < k; e++)
            begin
                it.batch_lines = 8'($urandom);
                it.pin         = PIN_W'($urandom);
                it.start_ms    = $urandom;
                it.line_edges  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
                it.edge_ms     = $urandom;
                it.line_end    = ($urandom_range(0, 2) == 0);
                it.batch_end   = (e == k - 1);
                send_item(it);
                sent++;
            end
            return;
        end
        big = ($urandom_range(0, 29) == 0);
        lim = (board.lim_lines == 0) ? 1 : board.lim_lines;
        cap = big ? 64 : 5;
        if (lim > cap)
            lim = cap;
        n_lines    = $urandom_range(1, lim);
        decl_lines = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(n_lines);
        drop_lend  = ($urandom_range(0, 24) == 0);
        taken      = '0;
        for (ln = 0; ln < n_lines; ln++)
        begin
            last = (ln == n_lines - 1);
            p    = $urandom_range(0, 63);
            if (taken != 0 && $urandom_range(0, 11) == 0)
                while (!taken[p]) p = (p + 1) % 64;
            else
                while (taken[p]) p = (p + 1) % 64;
            taken[p] = 1'b1;
            elim = (board.lim_edges == 0) ? 1 : board.lim_edges;
            cap  = (!big && $urandom_range(0, 32) == 0) ? 255 : 6;
            if (elim > cap)
                elim = cap;
            k = $urandom_range(1, elim);
            r = $urandom_range(0, 49);
            decl_edges = (r < 2) ? 8'd0 : (r < 5) ? 8'($urandom) : 8'(k);
            if ($urandom_range(0, 29) == 0)
                st = $urandom;
            else
                st = $urandom_range(board.lim_batch_ms / 2, 0);
            avail = longint'(board.lim_batch_ms) - longint'(st);
            if (avail < 0)
                avail = 0;
            top = avail / k;
            if (decl_edges == 0)
                k = 1;
            for (e = 0; e < k; e++)
            begin
                it.batch_lines = decl_lines;
                it.pin         = PIN_W'(p);
                it.start_ms    = st;
                it.line_edges  = decl_edges;
                if (e != 0 && $urandom_range(0, 24) == 0)
                begin
                    it.pin        = PIN_W'($urandom);
                    it.start_ms   = $urandom;
                    it.line_edges = 8'($urandom_range(0, 3));
                end
                if (board.lim_edge_ms > 0 && $urandom_range(0, 24) == 0)
                    it.edge_ms = $urandom_range(board.lim_edge_ms - 1, 0);
                else if ($urandom_range(0, 29) == 0)
                    it.edge_ms = $urandom;
                else if (top >= board.lim_edge_ms)
                    it.edge_ms = $urandom_range(32'(top), board.lim_edge_ms);
                else
                    it.edge_ms = board.lim_edge_ms;
                it.line_end  = (e == k - 1) && !(last && drop_lend);
                it.batch_end = last && (e == k - 1);
                send_item(it);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [6:0] lines, input logic [7:0] edges,
                             input logic [15:0] edge_floor, input logic [31:0] batch_ceiling,
                             input int target, input bit quiet);
        int sent;
        int total;
        settle();
        calm = quiet;
        write_limit(REG_MAX_LINES, 32'(lines));
        write_limit(REG_MAX_EDGES, 32'(edges));
        write_limit(REG_MIN_EDGE_MS, 32'(edge_floor));
        write_limit(REG_MAX_BATCH_MS, batch_ceiling);
        total = 0;
        while (total < target)
        begin
            send_batch(sent);
            total += sent;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        item_valid  = 1'b0;
        batch_lines = '0;
        pin         = '0;
        start_ms    = '0;
        line_edges  = '0;
        edge_ms     = '0;
        line_end    = 1'b0;
        batch_end   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // clean two-line batch, lowest and highest pin
        send_item(make_item(8'd2, 6'd0, 32'd100, 8'd2, 32'd10, 1'b0, 1'b0));
        send_item(make_item(8'd2, 6'd0, 32'd100, 8'd2, 32'd20, 1'b1, 1'b0));
        send_item(make_item(8'd2, 6'd63, 32'd0, 8'd1, 32'd1, 1'b1, 1'b1));
        // no lines
        send_item(make_item(8'd0, 6'd5, 32'd0, 8'd1, 32'd5, 1'b1, 1'b1));
        // too many lines wins over empty line
        send_item(make_item(8'd255, 6'd5, 32'd0, 8'd0, 32'd7, 1'b1, 1'b1));
        // empty line, edge value ignored
        send_item(make_item(8'd1, 6'd1, 32'd50, 8'd0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_item(make_item(8'd1, 6'd2, 32'd0, 8'd255, 32'd3, 1'b1, 1'b1));
        send_item(make_item(8'd1, 6'd3, 32'd0, 8'd1, 32'd0, 1'b1, 1'b1));
        // duplicate pin across lines
        send_item(make_item(8'd2, 6'd42, 32'd0, 8'd1, 32'd5, 1'b1, 1'b0));
        send_item(make_item(8'd2, 6'd42, 32'd0, 8'd1, 32'd5, 1'b1, 1'b1));
        // just over and exactly at the batch limit
        send_item(make_item(8'd1, 6'd7, 32'd30000, 8'd1, 32'd1, 1'b1, 1'b1));
        send_item(make_item(8'd1, 6'd7, 32'd29999, 8'd1, 32'd1, 1'b1, 1'b1));
        // saturating line sum
        send_item(make_item(8'd1, 6'd9, 32'hFFFF_FFFF, 8'd1, 32'hFFFF_FFFF, 1'b1, 1'b1));
        // batch end closes the open line; later per-line fields ignored
        send_item(make_item(8'd3, 6'd21, 32'd10, 8'd2, 32'd5, 1'b0, 1'b0));
        send_item(make_item(8'd0, 6'd22, 32'd999, 8'd2, 32'd6, 1'b0, 1'b1));
        // zero line_edges mid-line adds nothing
        send_item(make_item(8'd1, 6'd30, 32'd4, 8'd3, 32'd2, 1'b0, 1'b0));
        send_item(make_item(8'd1, 6'd30, 32'd4, 8'd0, 32'd100, 1'b1, 1'b1));
        // max edges exactly at limit
        send_item(make_item(8'd8, 6'd11, 32'd0, 8'd64, 32'd1, 1'b1, 1'b1));

        run_phase(7'd64, 8'd255, 16'd0, 32'hFFFF_FFFF, 300, 1'b0);
        run_phase(7'd1, 8'd1, 16'hFFFF, 32'd0, 100, 1'b0);
        run_phase(7'd4, 8'd8, 16'd10, 32'd5000, 300, 1'b0);
        run_phase(7'd0, 8'd0, 16'd1, 32'd1000, 50, 1'b0);
        run_phase(7'($urandom_range(1, 64)), 8'($urandom_range(1, 255)),
                  16'($urandom_range(0, 1000)), $urandom_range(1000000, 1000), 350, 1'b0);
        run_phase(7'd127, 8'd32, 16'd1, 32'd200000, 380, 1'b1);
        settle();

        if (board.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
